>>> rtl/cxau_pkg.sv
// ---------------------------------------------------------------------------
// cxau_pkg: shared definitions for the complex add/sub/divide unit
// Widths, fixed-point format, opcodes and pipeline depths.
// ---------------------------------------------------------------------------
package cxau_pkg;

  localparam int FRAC_BITS = 16;             // Q16.16 by default, 8..24 allowed
  localparam int DW        = 32;             // operand / result part width
  localparam int PW        = 2 * DW;         // full product width
  localparam int QW        = DW + 1;         // quotient bits resolved by the divider
  localparam int LANE_LAT  = QW + 1;         // divider lane: setup stage + one per bit

  localparam logic signed [DW-1:0] POS_MAX = {1'b0, {(DW-1){1'b1}}};
  localparam logic signed [DW-1:0] NEG_MIN = {1'b1, {(DW-1){1'b0}}};

  typedef enum logic [1:0] {
    OP_ADD  = 2'd0,
    OP_SUB  = 2'd1,
    OP_DIV  = 2'd2,
    OP_NONE = 2'd3        // unused code: all-zero result
  } op_e;

endpackage

>>> rtl/cxau_if.sv
// ---------------------------------------------------------------------------
// cxau_if: item channels of the complex arithmetic unit
// Valid/ready channels for operand items and result items.
// ---------------------------------------------------------------------------
interface cxau_in_if;
  logic                            valid;
  logic                            ready;
  logic [1:0]                      opcode;
  logic signed [cxau_pkg::DW-1:0]  left_real;
  logic signed [cxau_pkg::DW-1:0]  left_imag;
  logic signed [cxau_pkg::DW-1:0]  right_real;
  logic signed [cxau_pkg::DW-1:0]  right_imag;

  modport source (output valid, opcode, left_real, left_imag, right_real, right_imag,
                  input ready);
  modport sink   (input valid, opcode, left_real, left_imag, right_real, right_imag,
                  output ready);
endinterface

interface cxau_out_if;
  logic                            valid;
  logic                            ready;
  logic signed [cxau_pkg::DW-1:0]  result_real;
  logic signed [cxau_pkg::DW-1:0]  result_imag;
  logic                            divide_by_zero;
  logic                            saturated;

  modport source (output valid, result_real, result_imag, divide_by_zero, saturated,
                  input ready);
  modport sink   (input valid, result_real, result_imag, divide_by_zero, saturated,
                  output ready);
endinterface

>>> rtl/cxau_div_lane.sv
// ---------------------------------------------------------------------------
// cxau_div_lane: pipelined restoring divider, one quotient bit per stage
// Computes (num << FRAC_BITS) / den over LANE_LAT stages, with an overflow flag.
// ---------------------------------------------------------------------------
module cxau_div_lane (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  logic [cxau_pkg::PW-1:0]       num_i,
  input  logic [cxau_pkg::PW-1:0]       den_i,
  output logic [cxau_pkg::QW-1:0]       quo_o,
  output logic                          ovf_o
);

  localparam int SH = cxau_pkg::QW - cxau_pkg::FRAC_BITS;

  logic [cxau_pkg::PW-1:0] rem_q [0:cxau_pkg::QW];
  logic [cxau_pkg::PW-1:0] den_q [0:cxau_pkg::QW];
  logic [cxau_pkg::QW-1:0] low_q [0:cxau_pkg::QW];
  logic [cxau_pkg::QW-1:0] quo_q [0:cxau_pkg::QW];
  logic                    ovf_q [0:cxau_pkg::QW];

  logic [cxau_pkg::PW-1:0] rem0_d;

  // setup: top dividend bits form the first partial remainder; quotient
  // needing more than QW bits is flagged as overflow
  assign rem0_d = cxau_pkg::PW'(num_i >> SH);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= rem0_d;
      den_q[0] <= den_i;
      low_q[0] <= {num_i[SH-1:0], {cxau_pkg::FRAC_BITS{1'b0}}};
      quo_q[0] <= '0;
      ovf_q[0] <= (rem0_d >= den_i);
    end
  end

  for (genvar k = 1; k <= cxau_pkg::QW; k++) begin : g_bit
    logic [cxau_pkg::PW:0] sh_w;
    logic [cxau_pkg::PW:0] diff_w;
    logic                  ge_w;

    assign sh_w   = {rem_q[k-1], low_q[k-1][cxau_pkg::QW-1]};
    assign diff_w = sh_w - {1'b0, den_q[k-1]};
    assign ge_w   = (sh_w >= {1'b0, den_q[k-1]});

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= ge_w ? diff_w[cxau_pkg::PW-1:0] : sh_w[cxau_pkg::PW-1:0];
        den_q[k] <= den_q[k-1];
        low_q[k] <= {low_q[k-1][cxau_pkg::QW-2:0], 1'b0};
        quo_q[k] <= {quo_q[k-1][cxau_pkg::QW-2:0], ge_w};
        ovf_q[k] <= ovf_q[k-1];
      end
    end
  end

  assign quo_o = quo_q[cxau_pkg::QW];
  assign ovf_o = ovf_q[cxau_pkg::QW];

endmodule

>>> rtl/complex_add_sub_div_unit.sv
// ---------------------------------------------------------------------------
// complex_add_sub_div_unit: pipelined complex add / subtract / divide
// Q-format complex arithmetic with saturation and divide-by-zero flag.
// ---------------------------------------------------------------------------
// Takes one item per cycle unless a waiting result stalls the pipe, and
// returns one result item per item, in order. Parts are Q16.16 by default.
// There is one stage of six 32x32 multiplies, one of wide sums, one of
// sign/magnitude split, then the divider lanes, which resolve one quotient
// bit per stage over 33 stages plus a setup stage, then the output register.
// The whole pipe moves on one enable: it advances whenever the output
// register is empty or being taken, so input ready is formed directly from
// output ready and the output valid bit. Add and subtract are finished in
// the first stage and ride alongside the divide items.
// Divide truncates toward zero; every part saturates to the 32-bit range.
module complex_add_sub_div_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  cxau_in_if.sink    in_i,
  cxau_out_if.source out_o
);

  localparam int DW = cxau_pkg::DW;
  localparam int PW = cxau_pkg::PW;
  localparam int LL = cxau_pkg::LANE_LAT;

  // side info that travels alongside the divider lanes
  typedef struct packed {
    logic                 div;      // divide op with nonzero divisor
    logic                 dz;       // divide by zero
    logic signed [DW-1:0] re;       // finished add/sub result (else zero)
    logic signed [DW-1:0] im;
    logic                 sat;
    logic                 neg_r;    // sign of real numerator
    logic                 neg_i;    // sign of imaginary numerator
  } side_t;

  // global advance
  logic en;
  logic out_vld_q;
  assign en        = !out_vld_q || out_o.ready;
  assign in_i.ready = en;

  // ---------------- stage 1: products, add/sub ----------------
  logic                 v1_q;
  side_t                s1_d, s1_q;
  logic signed [PW-1:0] p_ac_q, p_bd_q, p_bc_q, p_ad_q, p_cc_q, p_dd_q;
  logic [DW:0]          sum_r, sum_i;
  logic                 ovr, ovi;
  logic                 is_add, is_sub, is_div, rz;

  assign is_add = (in_i.opcode == cxau_pkg::OP_ADD);
  assign is_sub = (in_i.opcode == cxau_pkg::OP_SUB);
  assign is_div = (in_i.opcode == cxau_pkg::OP_DIV);
  assign rz     = (in_i.right_real == '0) && (in_i.right_imag == '0);

  always_comb begin
    if (is_sub) begin
      sum_r = {in_i.left_real[DW-1], in_i.left_real} - {in_i.right_real[DW-1], in_i.right_real};
      sum_i = {in_i.left_imag[DW-1], in_i.left_imag} - {in_i.right_imag[DW-1], in_i.right_imag};
    end else begin
      sum_r = {in_i.left_real[DW-1], in_i.left_real} + {in_i.right_real[DW-1], in_i.right_real};
      sum_i = {in_i.left_imag[DW-1], in_i.left_imag} + {in_i.right_imag[DW-1], in_i.right_imag};
    end
    ovr = sum_r[DW] != sum_r[DW-1];
    ovi = sum_i[DW] != sum_i[DW-1];

    s1_d       = '0;
    s1_d.div   = is_div && !rz;
    s1_d.dz    = is_div && rz;
    if (is_add || is_sub) begin
      s1_d.re  = ovr ? (sum_r[DW] ? cxau_pkg::NEG_MIN : cxau_pkg::POS_MAX) : sum_r[DW-1:0];
      s1_d.im  = ovi ? (sum_i[DW] ? cxau_pkg::NEG_MIN : cxau_pkg::POS_MAX) : sum_i[DW-1:0];
      s1_d.sat = ovr || ovi;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_q   <= s1_d;
      p_ac_q <= in_i.left_real  * in_i.right_real;
      p_bd_q <= in_i.left_imag  * in_i.right_imag;
      p_bc_q <= in_i.left_imag  * in_i.right_real;
      p_ad_q <= in_i.left_real  * in_i.right_imag;
      p_cc_q <= in_i.right_real * in_i.right_real;
      p_dd_q <= in_i.right_imag * in_i.right_imag;
    end
  end

  // ---------------- stage 2: numerator and denominator sums ----------------
  logic                 v2_q;
  side_t                s2_q;
  logic signed [PW:0]   nr_q, ni_q;
  logic [PW-1:0]        den2_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_q   <= s1_q;
      nr_q   <= {p_ac_q[PW-1], p_ac_q} + {p_bd_q[PW-1], p_bd_q};
      ni_q   <= {p_bc_q[PW-1], p_bc_q} - {p_ad_q[PW-1], p_ad_q};
      den2_q <= p_cc_q + p_dd_q;      // both nonnegative, sum below 2^63 + 1
    end
  end

  // ---------------- stage 3: sign / magnitude ----------------
  logic                 v3_q;
  side_t                s3_d, s3_q;
  logic [PW-1:0]        mr_q, mi_q, den3_q;
  logic [PW:0]          abs_r, abs_i;

  assign abs_r = nr_q[PW] ? -nr_q : nr_q;
  assign abs_i = ni_q[PW] ? -ni_q : ni_q;

  always_comb begin
    s3_d       = s2_q;
    s3_d.neg_r = nr_q[PW];
    s3_d.neg_i = ni_q[PW];
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s3_q       <= s3_d;
      mr_q       <= abs_r[PW-1:0];
      mi_q       <= abs_i[PW-1:0];
      den3_q     <= den2_q;
    end
  end

  // ---------------- divider lanes ----------------
  logic [cxau_pkg::QW-1:0] qr, qi;
  logic                    fr, fi;

  cxau_div_lane u_lane_re (
    .clk_i (clk_i), .en_i (en), .num_i (mr_q), .den_i (den3_q), .quo_o (qr), .ovf_o (fr)
  );
  cxau_div_lane u_lane_im (
    .clk_i (clk_i), .en_i (en), .num_i (mi_q), .den_i (den3_q), .quo_o (qi), .ovf_o (fi)
  );

  side_t sd_q [0:LL-1];
  logic  vl_q [0:LL-1];

  always_ff @(posedge clk_i) begin
    if (en) begin
      sd_q[0] <= s3_q;
      for (int k = 1; k < LL; k++) begin
        sd_q[k] <= sd_q[k-1];
      end
    end
  end

  // ---------------- output stage: sign, saturate, select ----------------
  side_t                 sl;
  logic signed [DW-1:0]  re_d, im_d;
  logic                  sat_d, sr, si;
  logic signed [DW-1:0]  dr, di;
  logic [cxau_pkg::QW-1:0] lim_p, lim_n;

  assign sl    = sd_q[LL-1];
  assign lim_p = cxau_pkg::QW'(cxau_pkg::POS_MAX);
  assign lim_n = lim_p + cxau_pkg::QW'(1);

  always_comb begin
    sr = fr || (sl.neg_r ? (qr > lim_n) : (qr > lim_p));
    si = fi || (sl.neg_i ? (qi > lim_n) : (qi > lim_p));
    dr = sr ? (sl.neg_r ? cxau_pkg::NEG_MIN : cxau_pkg::POS_MAX)
            : (sl.neg_r ? -qr[DW-1:0] : qr[DW-1:0]);
    di = si ? (sl.neg_i ? cxau_pkg::NEG_MIN : cxau_pkg::POS_MAX)
            : (sl.neg_i ? -qi[DW-1:0] : qi[DW-1:0]);
    if (sl.div) begin
      re_d  = dr;
      im_d  = di;
      sat_d = sr || si;
    end else begin
      re_d  = sl.re;            // add/sub result, or zero for dz / unknown op
      im_d  = sl.im;
      sat_d = sl.sat;
    end
  end

  logic signed [DW-1:0] res_re_q, res_im_q;
  logic                 res_dz_q, res_sat_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      res_re_q  <= re_d;
      res_im_q  <= im_d;
      res_dz_q  <= sl.dz;
      res_sat_q <= sat_d;
    end
  end

  // valid bits, reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q      <= 1'b0;
      v2_q      <= 1'b0;
      v3_q      <= 1'b0;
      out_vld_q <= 1'b0;
      for (int k = 0; k < LL; k++) begin
        vl_q[k] <= 1'b0;
      end
    end else if (en) begin
      v1_q    <= in_i.valid;
      v2_q    <= v1_q;
      v3_q    <= v2_q;
      vl_q[0] <= v3_q;
      for (int k = 1; k < LL; k++) begin
        vl_q[k] <= vl_q[k-1];
      end
      out_vld_q <= vl_q[LL-1];
    end
  end

  assign out_o.valid          = out_vld_q;
  assign out_o.result_real    = res_re_q;
  assign out_o.result_imag    = res_im_q;
  assign out_o.divide_by_zero = res_dz_q;
  assign out_o.saturated      = res_sat_q;

`ifndef SYNTHESIS
  // an accepted item always lands in stage 1
  a_enter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> v1_q)
    else $error("accepted item lost at pipe entry");

  // backpressure only comes from a waiting result
  a_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> (out_o.valid && !out_o.ready))
    else $error("pipe stalled without a waiting result");

  // divide by zero gives a clean zero result
  a_dz: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.divide_by_zero) |->
      (out_o.result_real == '0 && out_o.result_imag == '0 && !out_o.saturated))
    else $error("divide by zero result not zero");
`endif

endmodule

>>> verif/testbench.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// testbench: complex add / subtract / divide unit
// Sends operand items through a valid/ready channel and checks every result
// item, in order, against a bit-accurate Q-format predictor of the unit.
// ---------------------------------------------------------------------------
module testbench;
  import cxau_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int N_RANDOM    = 1230;
  localparam int QUIET_FROM  = 1050;   // no idling after this many random items
  localparam int HOLD_CYCLES = 300;    // long receiver hold-off
  localparam int DRAIN_WAIT  = LANE_LAT + 20;

  typedef struct packed {
    logic signed [DW-1:0] re;
    logic signed [DW-1:0] im;
    logic                 dz;
    logic                 sat;
  } cx_result_t;

  // Expected-result store with the arithmetic predictor.
  class cx_scoreboard;
    cx_result_t expected_q[$];
    int         errors;

    function new();
      errors = 0;
    endfunction

    task report(input string what);
      $display("mismatch: %s", what);
      errors++;
    endtask

    function logic signed [DW-1:0] clamp(input logic signed [127:0] v, inout logic sat);
      if (v > 128'sd2147483647) begin
        sat = 1'b1;
        return POS_MAX;
      end
      if (v < -128'sd2147483648) begin
        sat = 1'b1;
        return NEG_MIN;
      end
      return v[DW-1:0];
    endfunction

    // truncated raw quotient, magnitude capped at 2^34 so clamp() saturates it
    function logic signed [127:0] quot(input logic signed [127:0] num,
                                       input logic [127:0] den);
      logic [127:0] mag;
      logic [127:0] q;
      mag = (num < 0) ? -num : num;
      q = (mag << FRAC_BITS) / den;
      if (q > 128'h4_0000_0000) q = 128'h4_0000_0000;
      return (num < 0) ? -$signed(q) : $signed(q);
    endfunction

    function cx_result_t compute(input logic [1:0] op,
                                 input logic signed [DW-1:0] a, b, c, d);
      cx_result_t r;
      logic signed [127:0] wa, wb, wc, wd, den;
      logic sat;
      wa = a; wb = b; wc = c; wd = d;
      sat = 1'b0;
      r = '0;
      case (op)
        OP_ADD: begin
          r.re = clamp(wa + wc, sat);
          r.im = clamp(wb + wd, sat);
        end
        OP_SUB: begin
          r.re = clamp(wa - wc, sat);
          r.im = clamp(wb - wd, sat);
        end
        OP_DIV: begin
          if (c == 0 && d == 0) begin
            r.dz = 1'b1;
          end else begin
            den  = wc * wc + wd * wd;
            r.re = clamp(quot(wa * wc + wb * wd, den), sat);
            r.im = clamp(quot(wb * wc - wa * wd, den), sat);
          end
        end
        default: ;  // unused opcode: all zero
      endcase
      r.sat = sat;
      return r;
    endfunction

    function void note_operands(input logic [1:0] op,
                                input logic signed [DW-1:0] a, b, c, d);
      expected_q.push_back(compute(op, a, b, c, d));
    endfunction

    task check_result(input cx_result_t got);
      cx_result_t exp_r;
      if (expected_q.size() == 0) begin
        report($sformatf("unexpected result re=%h im=%h", got.re, got.im));
        return;
      end
      exp_r = expected_q.pop_front();
      if (got.re !== exp_r.re)
        report($sformatf("result_real %h, expected %h", got.re, exp_r.re));
      if (got.im !== exp_r.im)
        report($sformatf("result_imag %h, expected %h", got.im, exp_r.im));
      if (got.dz !== exp_r.dz)
        report($sformatf("divide_by_zero %b, expected %b", got.dz, exp_r.dz));
      if (got.sat !== exp_r.sat)
        report($sformatf("saturated %b, expected %b", got.sat, exp_r.sat));
    endtask
  endclass

  logic clk_i;
  logic rst_ni;

  cxau_in_if  op_ch ();
  cxau_out_if res_ch ();

  complex_add_sub_div_unit DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (op_ch.sink),
    .out_o  (res_ch.source)
  );

  cx_scoreboard sb;
  int  cycle_cnt;
  bit  quiet;        // end of run: no idling on either side
  bit  hold_req;     // ask the receiver for one long hold-off
  bit  hold_done;
  int  hold_cnt;
  int  stall_cnt;

  always #5 clk_i = ~clk_i;

  // All inputs known from time zero.
  initial begin
    clk_i = 1'b0;
    rst_ni = 1'b0;
    op_ch.valid = 1'b0;
    op_ch.opcode = OP_ADD;
    op_ch.left_real = '0;
    op_ch.left_imag = '0;
    op_ch.right_real = '0;
    op_ch.right_imag = '0;
    res_ch.ready = 1'b0;
    quiet = 1'b0;
    hold_req = 1'b0;
    sb = new();
  end

  // Run guard.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end
  initial cycle_cnt = 0;

  // Receiver: check each taken result, then pick next ready. Random stall
  // bursts, plus one long hold-off so the pipe stalls and input ready drops.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (res_ch.valid && res_ch.ready)
        sb.check_result({res_ch.result_real, res_ch.result_imag,
                         res_ch.divide_by_zero, res_ch.saturated});
      if (hold_req && !hold_done) begin
        hold_done <= 1'b1;
        hold_cnt  <= HOLD_CYCLES;
        res_ch.ready <= 1'b0;
      end else if (hold_cnt > 0) begin
        hold_cnt <= hold_cnt - 1;
        res_ch.ready <= (hold_cnt == 1);
      end else if (stall_cnt > 0) begin
        stall_cnt <= stall_cnt - 1;
        res_ch.ready <= (stall_cnt == 1);
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        stall_cnt <= $urandom_range(1, 7);
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= 1'b1;
      end
    end
  end
  initial begin
    hold_done = 1'b0;
    hold_cnt = 0;
    stall_cnt = 0;
  end

  // Offer one item and hold it until taken.
  task automatic send_item(input logic [1:0] op, input logic [DW-1:0] a, b, c, d);
    op_ch.valid      <= 1'b1;
    op_ch.opcode     <= op;
    op_ch.left_real  <= a;
    op_ch.left_imag  <= b;
    op_ch.right_real <= c;
    op_ch.right_imag <= d;
    do @(posedge clk_i); while (!op_ch.ready);
    sb.note_operands(op, a, b, c, d);
  endtask

  task automatic maybe_idle();
    int n;
    if (!quiet && $urandom_range(0, 7) == 0) begin
      n = $urandom_range(1, 7);
      op_ch.valid <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  // Operand mix: full range, small values, extremes and zero.
  function automatic logic [DW-1:0] pick_part();
    case ($urandom_range(0, 9))
      0:       return 32'h7fff_ffff;
      1:       return 32'h8000_0000;
      2:       return '0;
      3, 4:    return $signed($urandom_range(0, 32'h3_ffff)) - 32'sh2_0000;
      5:       return $signed($urandom) >>> $urandom_range(0, 24);
      default: return $urandom;
    endcase
  endfunction

  initial begin : stimulus
    logic [1:0] op;
    logic [DW-1:0] c, d;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: extremes, every opcode, zero divisor, saturation both ways
    send_item(OP_ADD, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000);
    send_item(OP_ADD, 32'h0001_0000, 32'hffff_0000, 32'h0002_0000, 32'h0000_8000);
    send_item(OP_SUB, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000);
    send_item(OP_SUB, 32'h0000_0000, 32'h0000_0000, 32'h8000_0000, 32'h0000_0001);
    send_item(OP_SUB, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
    send_item(OP_DIV, 32'h0001_0000, 32'h0002_0000, 32'h0000_0000, 32'h0000_0000);
    send_item(OP_DIV, 32'h7fff_ffff, 32'h8000_0000, 32'h0000_0000, 32'h0000_0000);
    send_item(OP_DIV, 32'h0001_0000, 32'h0000_0000, 32'h0001_0000, 32'h0000_0000);
    send_item(OP_DIV, 32'h0003_0000, 32'h0004_0000, 32'h0001_0000, 32'hffff_0000);
    send_item(OP_DIV, 32'h8000_0000, 32'h8000_0000, 32'h0000_0001, 32'h0000_0000);
    send_item(OP_DIV, 32'h7fff_ffff, 32'h7fff_ffff, 32'h0000_0000, 32'h0000_0001);
    send_item(OP_DIV, 32'h0000_0000, 32'h0000_0000, 32'h1234_5678, 32'h8765_4321);
    send_item(OP_DIV, 32'h0000_0001, 32'hffff_ffff, 32'h7fff_ffff, 32'h8000_0000);
    send_item(OP_DIV, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000);
    send_item(OP_DIV, 32'hffff_0000, 32'h0000_8000, 32'h0000_0000, 32'h0002_0000);
    send_item(OP_NONE, 32'h1234_5678, 32'h7fff_ffff, 32'h8000_0000, 32'h0000_0001);
    send_item(OP_NONE, 32'hffff_ffff, 32'hffff_ffff, 32'h0000_0000, 32'h0000_0000);

    for (int i = 0; i < N_RANDOM; i++) begin
      if (i == QUIET_FROM) quiet = 1'b1;
      if (i == 300) hold_req = 1'b1;
      if (i == 600) begin
        // let the pipe drain completely before going on
        op_ch.valid <= 1'b0;
        while (sb.expected_q.size() != 0) @(posedge clk_i);
      end
      maybe_idle();
      op = ($urandom_range(0, 19) == 0) ? OP_NONE : 2'($urandom_range(0, 2));
      c = pick_part();
      d = pick_part();
      // zero divisor only now and then
      if (op == OP_DIV && c == 0 && d == 0 && $urandom_range(0, 3) != 0) c = 32'h0001_0000;
      send_item(op, pick_part(), pick_part(), c, d);
    end
    op_ch.valid <= 1'b0;

    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (sb.expected_q.size() != 0)
      sb.report("results still expected at end of run");
    if (sb.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
